// File: rtl/core/xibe_pkg.sv
// shared types and constants for the x86 instruction byte emitter
package xibe_pkg;

	// fixed encoding bytes
	localparam logic [7:0] BYTE_ADDR_SIZE = 8'h67;
	localparam logic [7:0] BYTE_OPND_SIZE = 8'h66;
	localparam logic [7:0] BYTE_REP       = 8'hF3;
	localparam logic [7:0] BYTE_ESCAPE    = 8'h0F;
	localparam logic [7:0] BYTE_ESC_38    = 8'h38;
	localparam logic [7:0] BYTE_ESC_3A    = 8'h3A;
	localparam logic [3:0] REX_HIGH       = 4'h4;

	// rm value that tells the decoder a sib byte follows
	localparam logic [2:0] SIB_MARKER_RM  = 3'd4;

	// escape kinds
	localparam logic [1:0] ESC_NONE = 2'd0;
	localparam logic [1:0] ESC_0F   = 2'd1;
	localparam logic [1:0] ESC_0F38 = 2'd2;
	localparam logic [1:0] ESC_0F3A = 2'd3;

	// displacement kinds
	localparam logic [1:0] DISP_NONE  = 2'd0;
	localparam logic [1:0] DISP_SHORT = 2'd1;
	localparam logic [1:0] DISP_LONG  = 2'd2;

	// modrm mod values that imply a displacement
	localparam logic [1:0] MOD_DISP8  = 2'd1;
	localparam logic [1:0] MOD_DISP32 = 2'd2;

	// part codes on the result
	localparam logic [2:0] PART_PREFIX = 3'd0;
	localparam logic [2:0] PART_REX    = 3'd1;
	localparam logic [2:0] PART_ESCAPE = 3'd2;
	localparam logic [2:0] PART_OPCODE = 3'd3;
	localparam logic [2:0] PART_MODRM  = 3'd4;
	localparam logic [2:0] PART_SIB    = 3'd5;
	localparam logic [2:0] PART_DISP   = 3'd6;
	localparam logic [2:0] PART_IMM    = 3'd7;

	// immediate is at most eight bytes
	localparam logic [3:0] IMM_MAX_BYTES = 4'd8;

	// classified item as it travels from front to back
	typedef struct packed {
		logic            err;
		logic [3:0][7:0] pfx_bytes;
		logic [2:0]      pfx_cnt;
		logic            rex_on;
		logic [7:0]      rex_byte;
		logic [1:0]      esc_cnt;
		logic [7:0]      esc2;
		logic [7:0]      opcode;
		logic            modrm_on;
		logic [7:0]      modrm_byte;
		logic            sib_on;
		logic [7:0]      sib_byte;
		logic [2:0]      disp_cnt;
		logic [31:0]     disp;
		logic [3:0]      imm_cnt;
		logic [63:0]     imm;
	} item_rec_t;

endpackage

// File: rtl/core/xibe_front.sv
// front end: accepts an instruction item and classifies it into byte groups
module xibe_front import xibe_pkg::*; (
	input  logic               start,
	input  logic               full,
	output logic               busy,
	output logic               push,
	input  logic [3:0]         prefix_flags,
	input  logic [4:0]         rex_control,
	input  logic [1:0]         escape_kind,
	input  logic [7:0]         opcode_byte,
	input  logic [8:0]         modrm_control,
	input  logic [5:0]         sib_control,
	input  logic [1:0]         disp_kind,
	input  logic signed [31:0] disp_value,
	input  logic [3:0]         imm_bytes,
	input  logic [63:0]        imm_value,
	input  logic               addr16,
	output item_rec_t          rec
);

	localparam logic [3:0][7:0] PFX_VALUES = {BYTE_REP, BYTE_OPND_SIZE, BYTE_OPND_SIZE,
		BYTE_ADDR_SIZE};

	logic       modrm_on;
	logic       sib_on;
	logic [1:0] mod_f;
	logic [2:0] rm_f;
	logic [2:0] long_cnt;
	logic [2:0] pcnt;

	// accept whenever the queue has room
	assign busy = full;
	assign push = start && !full;

	assign modrm_on = modrm_control[8];
	assign sib_on   = sib_control[5];
	assign mod_f    = modrm_control[7:6];
	assign rm_f     = modrm_control[2:0];
	assign long_cnt = addr16 ? 3'd2 : 3'd4;

	// classify the item
	always_comb begin
		rec  = '0;
		pcnt = '0;
		rec.err = sib_on && !modrm_on;

		// compact the prefixes in emission order
		for (int k = 0; k < 4; k++) begin
			if (prefix_flags[k]) begin
				rec.pfx_bytes[pcnt[1:0]] = PFX_VALUES[k];
				pcnt = pcnt + 3'd1;
			end
		end
		rec.pfx_cnt = pcnt;

		rec.rex_on   = rex_control[4];
		rec.rex_byte = {REX_HIGH, rex_control[3:0]};

		unique case (escape_kind)
			ESC_NONE: begin
				rec.esc_cnt = 2'd0;
			end
			ESC_0F: begin
				rec.esc_cnt = 2'd1;
			end
			ESC_0F38: begin
				rec.esc_cnt = 2'd2;
				rec.esc2    = BYTE_ESC_38;
			end
			ESC_0F3A: begin
				rec.esc_cnt = 2'd2;
				rec.esc2    = BYTE_ESC_3A;
			end
			default: begin
				rec.esc_cnt = 2'd0;
			end
		endcase

		rec.opcode     = opcode_byte;
		rec.modrm_on   = modrm_on;
		rec.modrm_byte = {mod_f, modrm_control[5:3], sib_on ? SIB_MARKER_RM : rm_f};
		rec.sib_on     = sib_on && modrm_on;
		rec.sib_byte   = {sib_control[4:3], sib_control[2:0], rm_f};

		// explicit displacement wins, else zero filler that mod asks for
		priority if (disp_kind == DISP_SHORT) begin
			rec.disp_cnt = 3'd1;
			rec.disp     = unsigned'(disp_value);
		end else if (disp_kind == DISP_LONG) begin
			rec.disp_cnt = long_cnt;
			rec.disp     = unsigned'(disp_value);
		end else if (modrm_on && mod_f == MOD_DISP8) begin
			rec.disp_cnt = 3'd1;
		end else if (modrm_on && mod_f == MOD_DISP32) begin
			rec.disp_cnt = long_cnt;
		end else begin
			rec.disp_cnt = 3'd0;
		end

		rec.imm_cnt = (imm_bytes > IMM_MAX_BYTES) ? IMM_MAX_BYTES : imm_bytes;
		rec.imm     = imm_value;
	end

endmodule

// File: rtl/core/xibe_queue.sv
// short item queue between the front end and the byte sequencer
module xibe_queue import xibe_pkg::*; #(
	parameter int DEPTH = 2
) (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      push,
	input  item_rec_t wr_item,
	output logic      full,
	input  logic      pop,
	output item_rec_t rd_item,
	output logic      empty
);

	localparam int PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CW = $clog2(DEPTH + 1);
	localparam logic [PW-1:0] LAST_PTR = PW'(DEPTH - 1);
	localparam logic [CW-1:0] FULL_CNT = CW'(DEPTH);

	item_rec_t     slots_q [DEPTH];
	logic [PW-1:0] wr_ptr_q;
	logic [PW-1:0] rd_ptr_q;
	logic [CW-1:0] count_q;

	assign full    = (count_q == FULL_CNT);
	assign empty   = (count_q == '0);
	assign rd_item = slots_q[rd_ptr_q];

	// storage
	always_ff @(posedge clk) begin
		if (push) begin
			slots_q[wr_ptr_q] <= wr_item;
		end
	end

	// pointers and fill count
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == LAST_PTR) ? '0 : wr_ptr_q + PW'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == LAST_PTR) ? '0 : rd_ptr_q + PW'(1);
			end
			if (push && !pop) begin
				count_q <= count_q + CW'(1);
			end else if (pop && !push) begin
				count_q <= count_q - CW'(1);
			end
		end
	end

	// no pop from an empty queue, no push into a full one
	a_no_underflow: assert property (@(posedge clk) disable iff (!arst_n)
		pop |-> count_q != '0) else $error("queue popped while empty");
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> count_q != FULL_CNT) else $error("queue pushed while full");

endmodule

// File: rtl/core/xibe_back.sv
// byte sequencer: walks the byte groups of one item, one byte per cycle
module xibe_back import xibe_pkg::*; (
	input  logic      clk,
	input  logic      arst_n,
	input  logic      q_empty,
	input  item_rec_t q_head,
	output logic      pop,
	output logic      strobe,
	output logic [7:0] out_byte,
	output logic [4:0] byte_offset,
	output logic [2:0] part_code,
	output logic      last_byte,
	output logic      encode_error
);

	// bits 9..2 follow the byte groups in emission order
	typedef enum logic [9:0] {
		ST_IDLE = 10'b00_0000_0001,
		ST_ERR  = 10'b00_0000_0010,
		ST_PFX  = 10'b00_0000_0100,
		ST_REX  = 10'b00_0000_1000,
		ST_ESC  = 10'b00_0001_0000,
		ST_OPC  = 10'b00_0010_0000,
		ST_MRM  = 10'b00_0100_0000,
		ST_SIB  = 10'b00_1000_0000,
		ST_DSP  = 10'b01_0000_0000,
		ST_IMM  = 10'b10_0000_0000
	} st_t;

	st_t        st_q;
	logic [2:0] sub_q;
	logic [4:0] off_q;
	item_rec_t  cur_q;

	logic [7:0] out_byte_q;
	logic [4:0] byte_offset_q;
	logic [2:0] part_code_q;
	logic       last_byte_q;
	logic       err_q;
	logic       strobe_q;

	logic [7:0] has_cur;
	logic [7:0] has_head;
	logic [7:0] ph_cur;
	logic [7:0] later;
	logic [7:0] next_ph;
	logic [7:0] head_first;
	logic [3:0] cnt;
	logic [7:0] cur_byte;
	logic [2:0] cur_part;
	logic       sub_last;
	logic       done;
	logic       emitting;

	// which byte groups an item has
	function automatic logic [7:0] group_mask(input item_rec_t r);
		group_mask = {r.imm_cnt != '0, r.disp_cnt != '0, r.sib_on, r.modrm_on, 1'b1,
			r.esc_cnt != '0, r.rex_on, r.pfx_cnt != '0};
	endfunction

	// next group after the current one, and first group of the queued item
	assign has_cur    = group_mask(cur_q);
	assign has_head   = group_mask(q_head);
	assign ph_cur     = st_q[9:2];
	assign later      = has_cur & ~(ph_cur | (ph_cur - 8'd1));
	assign next_ph    = later & (~later + 8'd1);
	assign head_first = has_head & (~has_head + 8'd1);

	// byte, part and length of the current group
	always_comb begin
		cnt      = 4'd1;
		cur_byte = '0;
		cur_part = PART_PREFIX;
		unique case (st_q)
			ST_IDLE: begin
				cnt = 4'd0;
			end
			ST_ERR: begin
				cnt = 4'd1;
			end
			ST_PFX: begin
				cnt      = {1'b0, cur_q.pfx_cnt};
				cur_byte = cur_q.pfx_bytes[sub_q[1:0]];
				cur_part = PART_PREFIX;
			end
			ST_REX: begin
				cur_byte = cur_q.rex_byte;
				cur_part = PART_REX;
			end
			ST_ESC: begin
				cnt      = {2'b00, cur_q.esc_cnt};
				cur_byte = (sub_q == '0) ? BYTE_ESCAPE : cur_q.esc2;
				cur_part = PART_ESCAPE;
			end
			ST_OPC: begin
				cur_byte = cur_q.opcode;
				cur_part = PART_OPCODE;
			end
			ST_MRM: begin
				cur_byte = cur_q.modrm_byte;
				cur_part = PART_MODRM;
			end
			ST_SIB: begin
				cur_byte = cur_q.sib_byte;
				cur_part = PART_SIB;
			end
			ST_DSP: begin
				cnt      = {1'b0, cur_q.disp_cnt};
				cur_byte = cur_q.disp[{sub_q[1:0], 3'b000} +: 8];
				cur_part = PART_DISP;
			end
			ST_IMM: begin
				cnt      = cur_q.imm_cnt;
				cur_byte = cur_q.imm[{sub_q, 3'b000} +: 8];
				cur_part = PART_IMM;
			end
			default: begin
				cnt = 4'd0;
			end
		endcase
	end

	assign emitting = (st_q != ST_IDLE);
	assign sub_last = (({1'b0, sub_q} + 4'd1) == cnt);
	assign done     = (st_q == ST_ERR) || (sub_last && later == '0);
	assign pop      = !q_empty && (!emitting || done);

	// sequencer state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q  <= ST_IDLE;
			sub_q <= '0;
			off_q <= '0;
		end else begin
			if (pop) begin
				st_q  <= q_head.err ? ST_ERR : st_t'({head_first, 2'b00});
				sub_q <= '0;
				off_q <= '0;
			end else if (emitting) begin
				off_q <= off_q + 5'd1;
				if (done) begin
					st_q <= ST_IDLE;
				end else if (sub_last) begin
					st_q  <= st_t'({next_ph, 2'b00});
					sub_q <= '0;
				end else begin
					sub_q <= sub_q + 3'd1;
				end
			end
		end
	end

	// working item
	always_ff @(posedge clk) begin
		if (pop) begin
			cur_q <= q_head;
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			strobe_q <= 1'b0;
		end else begin
			strobe_q <= emitting;
		end
	end

	always_ff @(posedge clk) begin
		out_byte_q    <= cur_byte;
		byte_offset_q <= off_q;
		part_code_q   <= cur_part;
		last_byte_q   <= done;
		err_q         <= (st_q == ST_ERR);
	end

	assign strobe       = strobe_q;
	assign out_byte     = out_byte_q;
	assign byte_offset  = byte_offset_q;
	assign part_code    = part_code_q;
	assign last_byte    = last_byte_q;
	assign encode_error = err_q;

	// bytes of one item come back to back with rising offsets
	a_offset_step: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && !last_byte_q |=> strobe_q && byte_offset_q == $past(byte_offset_q) + 5'd1)
		else $error("item bytes not contiguous");
	// a new item starts at offset zero
	a_new_item_at_zero: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && last_byte_q |=> !strobe_q || byte_offset_q == '0)
		else $error("item does not start at offset zero");
	// an error result stands alone
	a_err_alone: assert property (@(posedge clk) disable iff (!arst_n)
		strobe_q && err_q |-> last_byte_q && byte_offset_q == '0 && out_byte_q == '0)
		else $error("error result not a lone result");

endmodule

// File: rtl/core/x86_instruction_byte_emitter.sv
// top level of the x86 instruction byte emitter
// An item is taken when start is high and busy is low; its bytes come out one per clock on
// out_byte with strobe high, tagged with byte_offset, part_code and last_byte, and the
// receiver cannot stall them. An item has 1 to 22 bytes, and consecutive items follow with
// no gap; a SIB request without ModRM gives a single result with encode_error. With the
// sequencer idle, a taken item is written into the queue, loaded into the sequencer state
// and then held in the result register before its first byte appears. Up to QUEUE_DEPTH
// classified items wait ahead of the sequencer; busy is high while that queue is full.
module x86_instruction_byte_emitter import xibe_pkg::*; #(
	parameter int QUEUE_DEPTH = 2
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [3:0]         prefix_flags,
	input  logic [4:0]         rex_control,
	input  logic [1:0]         escape_kind,
	input  logic [7:0]         opcode_byte,
	input  logic [8:0]         modrm_control,
	input  logic [5:0]         sib_control,
	input  logic [1:0]         disp_kind,
	input  logic signed [31:0] disp_value,
	input  logic [3:0]         imm_bytes,
	input  logic [63:0]        imm_value,
	input  logic               addr16,
	output logic               strobe,
	output logic [7:0]         out_byte,
	output logic [4:0]         byte_offset,
	output logic [2:0]         part_code,
	output logic               last_byte,
	output logic               encode_error
);

	item_rec_t front_rec;
	item_rec_t head_rec;
	logic      push;
	logic      full;
	logic      pop;
	logic      empty;

	// classify incoming items
	xibe_front u_front (
		.start         (start),
		.full          (full),
		.busy          (busy),
		.push          (push),
		.prefix_flags  (prefix_flags),
		.rex_control   (rex_control),
		.escape_kind   (escape_kind),
		.opcode_byte   (opcode_byte),
		.modrm_control (modrm_control),
		.sib_control   (sib_control),
		.disp_kind     (disp_kind),
		.disp_value    (disp_value),
		.imm_bytes     (imm_bytes),
		.imm_value     (imm_value),
		.addr16        (addr16),
		.rec           (front_rec)
	);

	// decoupling queue
	xibe_queue #(
		.DEPTH (QUEUE_DEPTH)
	) u_queue (
		.clk     (clk),
		.arst_n  (arst_n),
		.push    (push),
		.wr_item (front_rec),
		.full    (full),
		.pop     (pop),
		.rd_item (head_rec),
		.empty   (empty)
	);

	// emit bytes
	xibe_back u_back (
		.clk          (clk),
		.arst_n       (arst_n),
		.q_empty      (empty),
		.q_head       (head_rec),
		.pop          (pop),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.byte_offset  (byte_offset),
		.part_code    (part_code),
		.last_byte    (last_byte),
		.encode_error (encode_error)
	);

endmodule

// File: tb/sv/tb_x86_instruction_byte_emitter.sv
// self-checking testbench for the x86 instruction byte emitter
`timescale 1ns / 1ps

module tb_x86_instruction_byte_emitter import xibe_pkg::*;;

	localparam int CYCLE_LIMIT  = 200000;
	localparam int RANDOM_ITEMS = 255;
	localparam int CALM_TAIL    = 40;
	localparam int DRAIN_CYCLES = 40;

	// one instruction record as it goes into the block
	typedef struct packed {
		logic [3:0]  pfx;
		logic [4:0]  rex;
		logic [1:0]  esc;
		logic [7:0]  opc;
		logic [8:0]  modrm;
		logic [5:0]  sib;
		logic [1:0]  dkind;
		logic [31:0] disp;
		logic [3:0]  ilen;
		logic [63:0] imm;
		logic        a16;
	} instr_t;

	// one emitted byte with its tags
	typedef struct packed {
		logic [7:0] value;
		logic [4:0] offset;
		logic [2:0] part;
		logic       last;
		logic       err;
	} byte_rec_t;

	// directed row: a literal result where it is obvious, else the predictor
	typedef struct {
		instr_t    ins;
		logic      lit_on;
		byte_rec_t lit;
	} row_t;

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               start = 1'b0;
	logic               busy;
	logic [3:0]         prefix_flags = '0;
	logic [4:0]         rex_control = '0;
	logic [1:0]         escape_kind = '0;
	logic [7:0]         opcode_byte = '0;
	logic [8:0]         modrm_control = '0;
	logic [5:0]         sib_control = '0;
	logic [1:0]         disp_kind = '0;
	logic signed [31:0] disp_value = '0;
	logic [3:0]         imm_bytes = '0;
	logic [63:0]        imm_value = '0;
	logic               addr16 = 1'b0;
	logic               strobe;
	logic [7:0]         out_byte;
	logic [4:0]         byte_offset;
	logic [2:0]         part_code;
	logic               last_byte;
	logic               encode_error;

	byte_rec_t expected_bytes[$];
	byte_rec_t staged_bytes[$];
	row_t      directed_rows[$];
	int        mismatch_count = 0;
	int        cycle_count = 0;

	x86_instruction_byte_emitter i_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.start        (start),
		.busy         (busy),
		.prefix_flags (prefix_flags),
		.rex_control  (rex_control),
		.escape_kind  (escape_kind),
		.opcode_byte  (opcode_byte),
		.modrm_control(modrm_control),
		.sib_control  (sib_control),
		.disp_kind    (disp_kind),
		.disp_value   (disp_value),
		.imm_bytes    (imm_bytes),
		.imm_value    (imm_value),
		.addr16       (addr16),
		.strobe       (strobe),
		.out_byte     (out_byte),
		.byte_offset  (byte_offset),
		.part_code    (part_code),
		.last_byte    (last_byte),
		.encode_error (encode_error)
	);

	// clock
	always #2 clk = ~clk;

	// run watchdog
	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count > CYCLE_LIMIT) begin
			$display("[FAIL] regression broken");
			$finish;
		end
	end

	// queue one expected byte at the tail
	task automatic expect_byte(input byte_rec_t r);
		expected_bytes.insert(expected_bytes.size(), r);
	endtask

	// append one row to the directed table
	task automatic add_row(input instr_t ins, input logic lit_on, input byte_rec_t lit);
		row_t row;
		row.ins    = ins;
		row.lit_on = lit_on;
		row.lit    = lit;
		directed_rows.insert(directed_rows.size(), row);
	endtask

	// append one byte to the instruction being predicted
	task automatic stage_byte(input logic [7:0] v, input logic [2:0] part);
		byte_rec_t r;
		r.value  = v;
		r.offset = 5'(staged_bytes.size());
		r.part   = part;
		r.last   = 1'b0;
		r.err    = 1'b0;
		staged_bytes.insert(staged_bytes.size(), r);
	endtask

	// predict the byte stream of one instruction and queue it
	task automatic encode_expected(input instr_t it);
		logic [1:0]  mode;
		logic [2:0]  rm;
		logic [31:0] disp_src;
		int          long_len;
		int          disp_n;
		int          imm_n;
		byte_rec_t   r;
		mode     = it.modrm[7:6];
		rm       = it.modrm[2:0];
		long_len = it.a16 ? 2 : 4;
		staged_bytes.delete();
		// sib asked for without modrm: one error result only
		if (it.sib[5] && !it.modrm[8]) begin
			r = '{value: 8'h00, offset: 5'd0, part: PART_PREFIX, last: 1'b1, err: 1'b1};
			expect_byte(r);
			return;
		end
		// prefixes
		if (it.pfx[0]) stage_byte(BYTE_ADDR_SIZE, PART_PREFIX);
		if (it.pfx[1]) stage_byte(BYTE_OPND_SIZE, PART_PREFIX);
		if (it.pfx[2]) stage_byte(BYTE_OPND_SIZE, PART_PREFIX);
		if (it.pfx[3]) stage_byte(BYTE_REP, PART_PREFIX);
		if (it.rex[4]) stage_byte({REX_HIGH, it.rex[3:0]}, PART_REX);
		// escape bytes and opcode
		if (it.esc != ESC_NONE) stage_byte(BYTE_ESCAPE, PART_ESCAPE);
		if (it.esc == ESC_0F38) stage_byte(BYTE_ESC_38, PART_ESCAPE);
		if (it.esc == ESC_0F3A) stage_byte(BYTE_ESC_3A, PART_ESCAPE);
		stage_byte(it.opc, PART_OPCODE);
		// modrm, with rm replaced by the sib marker when sib follows
		if (it.modrm[8]) begin
			stage_byte({mode, it.modrm[5:3], it.sib[5] ? SIB_MARKER_RM : rm}, PART_MODRM);
			if (it.sib[5]) stage_byte({it.sib[4:3], it.sib[2:0], rm}, PART_SIB);
		end
		// explicit displacement, or zero filler that mod calls for
		disp_src = it.disp;
		disp_n   = 0;
		if (it.dkind == DISP_SHORT) begin
			disp_n = 1;
		end else if (it.dkind == DISP_LONG) begin
			disp_n = long_len;
		end else begin
			disp_src = '0;
			if (it.modrm[8] && mode == MOD_DISP8) disp_n = 1;
			else if (it.modrm[8] && mode == MOD_DISP32) disp_n = long_len;
		end
		for (int i = 0; i < disp_n; i++) stage_byte(disp_src[8*i +: 8], PART_DISP);
		// immediate, saturated to eight bytes
		imm_n = (it.ilen > IMM_MAX_BYTES) ? int'(IMM_MAX_BYTES) : int'(it.ilen);
		for (int i = 0; i < imm_n; i++) stage_byte(it.imm[8*i +: 8], PART_IMM);
		staged_bytes[staged_bytes.size()-1].last = 1'b1;
		foreach (staged_bytes[k]) expect_byte(staged_bytes[k]);
	endtask

	// present one instruction and hold it until the block takes it
	task automatic issue_instruction(input instr_t it, input logic lit_on, input byte_rec_t lit);
		prefix_flags  <= it.pfx;
		rex_control   <= it.rex;
		escape_kind   <= it.esc;
		opcode_byte   <= it.opc;
		modrm_control <= it.modrm;
		sib_control   <= it.sib;
		disp_kind     <= it.dkind;
		disp_value    <= it.disp;
		imm_bytes     <= it.ilen;
		imm_value     <= it.imm;
		addr16        <= it.a16;
		start         <= 1'b1;
		do @(posedge clk); while (busy !== 1'b0);
		if (lit_on) expect_byte(lit);
		else encode_expected(it);
	endtask

	// random burst of sender idling
	task automatic sender_gap(input logic allowed);
		if (allowed && $urandom_range(0, 3) == 0) begin
			start <= 1'b0;
			repeat ($urandom_range(1, 11)) @(posedge clk);
		end
	endtask

	function automatic instr_t mk(input logic [3:0] pfx, input logic [4:0] rex,
			input logic [1:0] esc, input logic [7:0] opc, input logic [8:0] modrm,
			input logic [5:0] sib, input logic [1:0] dkind, input logic [31:0] disp,
			input logic [3:0] ilen, input logic [63:0] imm, input logic a16);
		instr_t it;
		it = '{pfx, rex, esc, opc, modrm, sib, dkind, disp, ilen, imm, a16};
		return it;
	endfunction

	// random instruction, mostly well formed, some error and out-of-range kinds
	function automatic instr_t random_instruction();
		instr_t it;
		int     pick;
		pick     = $urandom_range(0, 99);
		it.pfx   = 4'($urandom);
		it.rex   = 5'($urandom);
		it.esc   = 2'($urandom);
		it.opc   = 8'($urandom);
		it.modrm = {($urandom_range(0, 99) < 80), 8'($urandom)};
		it.sib   = {($urandom_range(0, 99) < 40), 5'($urandom)};
		it.dkind = ($urandom_range(0, 19) == 0) ? 2'd3 : 2'($urandom_range(0, 2));
		it.disp  = $urandom;
		it.ilen  = ($urandom_range(0, 19) == 0) ? 4'($urandom_range(9, 15))
		                                        : 4'($urandom_range(0, 8));
		it.imm   = {$urandom, $urandom};
		it.a16   = 1'($urandom);
		if (pick < 6) it.modrm[8] = 1'b0;
		if (pick < 6) it.sib[5] = 1'b1;
		else if (pick < 15) it.sib[5] = 1'b0;
		return it;
	endfunction

	// result checker: every strobe is compared with the oldest expectation
	always @(posedge clk) begin
		byte_rec_t want;
		if (arst_n && strobe !== 1'b0) begin
			if (expected_bytes.size() == 0) begin
				$error("unexpected result: out_byte %h offset %0d part %0d",
					out_byte, byte_offset, part_code);
				mismatch_count++;
			end else begin
				want = expected_bytes.pop_front();
				if (strobe !== 1'b1) begin
					$error("strobe: expected 1, got %b", strobe);
					mismatch_count++;
				end
				if (out_byte !== want.value) begin
					$error("out_byte: expected %h, got %h", want.value, out_byte);
					mismatch_count++;
				end
				if (byte_offset !== want.offset) begin
					$error("byte_offset: expected %0d, got %0d", want.offset, byte_offset);
					mismatch_count++;
				end
				if (part_code !== want.part) begin
					$error("part_code: expected %0d, got %0d", want.part, part_code);
					mismatch_count++;
				end
				if (last_byte !== want.last) begin
					$error("last_byte: expected %b, got %b", want.last, last_byte);
					mismatch_count++;
				end
				if (encode_error !== want.err) begin
					$error("encode_error: expected %b, got %b", want.err, encode_error);
					mismatch_count++;
				end
			end
		end
	end

	// stimulus
	initial begin
		byte_rec_t none;
		byte_rec_t err_rec;
		instr_t    it;
		none    = '0;
		err_rec = '{value: 8'h00, offset: 5'd0, part: PART_PREFIX, last: 1'b1, err: 1'b1};

		// bare opcodes at both extremes
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h00, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b1,
			'{value: 8'h00, offset: 5'd0, part: PART_OPCODE, last: 1'b1, err: 1'b0});
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hFF, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b1,
			'{value: 8'hFF, offset: 5'd0, part: PART_OPCODE, last: 1'b1, err: 1'b0});
		// sib without modrm, all else at its maximum, then minimal
		add_row(mk(4'hF, 5'h1F, ESC_0F3A, 8'hFF, 9'h0FF, 6'h3F, 2'd3,
			32'hFFFF_FFFF, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b1), 1'b1, err_rec);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h00, 9'h000, 6'h20, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b1, err_rec);
		// prefixes, rex and escapes
		add_row(mk(4'hF, 5'h00, ESC_NONE, 8'h90, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h10, ESC_NONE, 8'h01, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h5, 5'h1F, ESC_0F, 8'hAF, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'hA, 5'h1A, ESC_0F38, 8'h00, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h15, ESC_0F3A, 8'h0F, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		// modrm with every mod and no displacement given
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h8B, {1'b1, 2'd0, 3'd7, 3'd5},
			6'h00, DISP_NONE, 32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h8B, {1'b1, MOD_DISP8, 3'd2, 3'd1},
			6'h00, DISP_NONE, 32'h1234_5678, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h89, {1'b1, MOD_DISP32, 3'd0, 3'd3},
			6'h00, DISP_NONE, 32'hDEAD_BEEF, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h1, 5'h00, ESC_NONE, 8'h89, {1'b1, MOD_DISP32, 3'd0, 3'd3},
			6'h00, DISP_NONE, 32'h0, 4'd0, 64'h0, 1'b1), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h01, {1'b1, 2'd3, 3'd7, 3'd7},
			6'h00, DISP_NONE, 32'h0, 4'd0, 64'h0, 1'b0), 1'b0, none);
		// explicit displacements whatever mod says, and kind three
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h8D, {1'b1, 2'd0, 3'd1, 3'd2},
			6'h00, DISP_SHORT, 32'hFFFF_FF80, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hA1, 9'h000, 6'h00, DISP_LONG,
			32'h8000_0000, 4'd0, 64'h0, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hA1, {1'b1, MOD_DISP8, 3'd0, 3'd0},
			6'h00, DISP_LONG, 32'h7FFF_FFFF, 4'd0, 64'h0, 1'b1), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'h8B, {1'b1, MOD_DISP8, 3'd4, 3'd6},
			6'h00, 2'd3, 32'hFFFF_FFFF, 4'd0, 64'h0, 1'b0), 1'b0, none);
		// sib with base taken from rm
		add_row(mk(4'h0, 5'h18, ESC_NONE, 8'h8B, {1'b1, MOD_DISP32, 3'd3, 3'd7},
			6'h3D, DISP_NONE, 32'h0, 4'd0, 64'h0, 1'b1), 1'b0, none);
		// immediates, including lengths past eight
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hB0, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd1, 64'h0123_4567_89AB_CDEF, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h18, ESC_NONE, 8'hB8, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd8, 64'h8000_0000_0000_0001, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hB8, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'd9, 64'hFEDC_BA98_7654_3210, 1'b0), 1'b0, none);
		add_row(mk(4'h0, 5'h00, ESC_NONE, 8'hB8, 9'h000, 6'h00, DISP_NONE,
			32'h0, 4'hF, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0), 1'b0, none);
		// longest instruction: 22 bytes
		add_row(mk(4'hF, 5'h1F, ESC_0F3A, 8'hFF, 9'h1FF, 6'h3F, DISP_LONG,
			32'h8000_0000, 4'd8, 64'hFFFF_FFFF_FFFF_FFFF, 1'b0), 1'b0, none);

		// reset
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed part
		foreach (directed_rows[k]) begin
			issue_instruction(directed_rows[k].ins, directed_rows[k].lit_on, directed_rows[k].lit);
			sender_gap(1'b1);
		end

		// random part, with no idling near the end
		for (int n = 0; n < RANDOM_ITEMS; n++) begin
			it = random_instruction();
			issue_instruction(it, 1'b0, none);
			sender_gap(n < RANDOM_ITEMS - CALM_TAIL);
		end
		start <= 1'b0;

		// drain
		while (expected_bytes.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (mismatch_count == 0) begin
			$display("[ OK ] regression clean");
		end else begin
			$display("[FAIL] regression broken");
		end
		$finish;
	end

endmodule

// File: sim.f
rtl/core/xibe_pkg.sv
rtl/core/xibe_front.sv
rtl/core/xibe_queue.sv
rtl/core/xibe_back.sv
rtl/core/x86_instruction_byte_emitter.sv
tb/sv/tb_x86_instruction_byte_emitter.sv
